[design/tffn_pkg.sv]
package tffn_pkg;

    // Sequencer states of the normal unit
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_CROSS,
        ST_MAX,
        ST_NORM,
        ST_SQ,
        ST_SQRT,
        ST_DIV,
        ST_NEXT,
        ST_OUT
    } state_t;

    localparam int NORM_ONE_SHIFT = 14;
    localparam int SH_WIDTH       = 32;   // shifted magnitude width
    localparam int SUM_WIDTH      = 64;
    localparam int ROOT_WIDTH     = 32;
    localparam int DIV_WIDTH      = 48;   // dividend q*2^14 + r/2
    localparam int NORM_WIDTH     = 16;

endpackage

[design/triangle_fan_face_normals.sv]
// A point that closes a triangle shows it once its request is taken and the block has run
// serial products, normalising shifts, squares, a root and three restoring divisions (a
// degenerate one goes from the products straight to the output).
// Throughput: points that emit nothing are taken one a cycle; the input stalls while a
// triangle is worked out and until it is taken.
// Reset (rst_n low, asynchronous): state, point count, first and previous points and handshake cleared.
module triangle_fan_face_normals #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          start_req,
    input  logic signed [COORD_WIDTH-1:0] pos_x,
    input  logic signed [COORD_WIDTH-1:0] pos_y,
    input  logic signed [COORD_WIDTH-1:0] pos_z,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [COORD_WIDTH-1:0] a_x,
    output logic signed [COORD_WIDTH-1:0] a_y,
    output logic signed [COORD_WIDTH-1:0] a_z,
    output logic signed [COORD_WIDTH-1:0] b_x,
    output logic signed [COORD_WIDTH-1:0] b_y,
    output logic signed [COORD_WIDTH-1:0] b_z,
    output logic signed [COORD_WIDTH-1:0] c_x,
    output logic signed [COORD_WIDTH-1:0] c_y,
    output logic signed [COORD_WIDTH-1:0] c_z,
    output logic signed [15:0]            norm_x,
    output logic signed [15:0]            norm_y,
    output logic signed [15:0]            norm_z
);

    localparam int DW  = COORD_WIDTH + 1;          // difference width
    localparam int PW  = 2 * DW;                   // product width
    localparam int CW  = PW + 1;                   // cross component width
    localparam int MW  = CW - 1;                   // magnitude width
    localparam int MXW = (MW > 32) ? MW : 32;      // largest magnitude, room to shift up
    localparam int CNTW = $clog2(PW + 1) + 1;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    tffn_pkg::state_t state_reg, state_next;

    coord_t fx_reg, fy_reg, fz_reg, px_reg, py_reg, pz_reg;
    coord_t cx_reg, cy_reg, cz_reg;
    logic [1:0] count_reg;

    // Differences u = b - a, v = c - a
    logic signed [DW-1:0] u_reg [3];
    logic signed [DW-1:0] v_reg [3];

    // Serial multiplier: six products, one multiplier bit per cycle
    logic [2:0]             pidx_reg;
    logic [CNTW-1:0]        bit_reg;
    logic signed [PW-1:0]   acc_reg;
    logic [DW-1:0]          mplr_reg;
    logic signed [PW-1:0]   mcand_reg;
    logic signed [PW-1:0]   prod_reg [6];

    logic signed [CW-1:0]   cr_reg [3];
    logic [MW-1:0]          mag_reg [3];
    logic [MXW-1:0]         m_reg;
    logic [tffn_pkg::SH_WIDTH-1:0] q_reg [3];

    logic [tffn_pkg::SUM_WIDTH-1:0]  s_reg;
    logic [tffn_pkg::SUM_WIDTH-1:0]  rem_reg;
    logic [tffn_pkg::ROOT_WIDTH-1:0] root_reg;
    logic [1:0]                      ci_reg;

    logic [tffn_pkg::DIV_WIDTH-1:0]  dvd_reg;
    logic [tffn_pkg::DIV_WIDTH-1:0]  drem_reg;
    logic [tffn_pkg::DIV_WIDTH-1:0]  quo_reg;
    logic [15:0]                     n_reg [3];
    logic                            zero_reg;

    logic out_valid_reg;
    logic accept;
    logic emit;
    logic mag_zero;
    logic mul_last, sq_last, sqrt_last, div_last, max_big, max_small;

    assign in_stall = (state_reg != tffn_pkg::ST_IDLE) || out_valid_reg;
    assign accept   = in_valid && !in_stall;
    assign emit     = !start_req && (count_reg == 2'd2);
    assign mag_zero = ((mag_reg[0] | mag_reg[1] | mag_reg[2]) == '0);

    assign mul_last  = (bit_reg == CNTW'(DW - 1));
    assign sq_last   = (bit_reg == CNTW'(tffn_pkg::SH_WIDTH - 1));
    assign sqrt_last = (bit_reg == CNTW'(tffn_pkg::ROOT_WIDTH - 1));
    assign div_last  = (bit_reg == CNTW'(tffn_pkg::DIV_WIDTH - 1));
    assign max_big   = (m_reg >= (MXW'(1) << 31));
    assign max_small = (m_reg < (MXW'(1) << 30));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tffn_pkg::ST_IDLE:  if (accept && emit) state_next = tffn_pkg::ST_MUL;
            tffn_pkg::ST_MUL:   if (mul_last && pidx_reg == 3'd5)
                                    state_next = tffn_pkg::ST_CROSS;
            tffn_pkg::ST_CROSS: state_next = tffn_pkg::ST_MAX;
            tffn_pkg::ST_MAX:   state_next = mag_zero ? tffn_pkg::ST_OUT
                                                      : tffn_pkg::ST_NORM;
            tffn_pkg::ST_NORM:  if (!max_big && !max_small) state_next = tffn_pkg::ST_SQ;
            tffn_pkg::ST_SQ:    if (sq_last && ci_reg == 2'd2) state_next = tffn_pkg::ST_SQRT;
            tffn_pkg::ST_SQRT:  if (sqrt_last) state_next = tffn_pkg::ST_NEXT;
            tffn_pkg::ST_NEXT:  state_next = tffn_pkg::ST_DIV;
            tffn_pkg::ST_DIV:   if (div_last)
                                    state_next = (ci_reg == 2'd2) ? tffn_pkg::ST_OUT
                                                                  : tffn_pkg::ST_NEXT;
            tffn_pkg::ST_OUT:   state_next = tffn_pkg::ST_IDLE;
            default:            state_next = tffn_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tffn_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Point store and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            fx_reg <= '0; fy_reg <= '0; fz_reg <= '0;
            px_reg <= '0; py_reg <= '0; pz_reg <= '0;
        end
        else if (accept)
        begin
            if (start_req || count_reg == 2'd0)
            begin
                fx_reg <= pos_x; fy_reg <= pos_y; fz_reg <= pos_z;
                px_reg <= pos_x; py_reg <= pos_y; pz_reg <= pos_z;
                count_reg <= 2'd1;
            end
            else if (count_reg == 2'd1)
            begin
                px_reg <= pos_x; py_reg <= pos_y; pz_reg <= pos_z;
                count_reg <= 2'd2;
            end
        end
        else if (out_valid_reg && !out_stall)
        begin
            // advance previous point once the triangle is taken
            px_reg <= cx_reg; py_reg <= cy_reg; pz_reg <= cz_reg;
        end
    end

    // Output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == tffn_pkg::ST_OUT)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Datapath: differences, serial products, cross, normalise, squares, root, divide
    always_ff @(posedge clk)
    begin
        case (state_reg)
            tffn_pkg::ST_IDLE:
            begin
                if (accept && emit)
                begin
                    cx_reg <= pos_x; cy_reg <= pos_y; cz_reg <= pos_z;
                    u_reg[0] <= DW'(px_reg) - DW'(fx_reg);
                    u_reg[1] <= DW'(py_reg) - DW'(fy_reg);
                    u_reg[2] <= DW'(pz_reg) - DW'(fz_reg);
                    v_reg[0] <= DW'(pos_x) - DW'(fx_reg);
                    v_reg[1] <= DW'(pos_y) - DW'(fy_reg);
                    v_reg[2] <= DW'(pos_z) - DW'(fz_reg);
                    // first product u1*v2
                    mcand_reg <= PW'(DW'(py_reg) - DW'(fy_reg));
                    mplr_reg  <= DW'(pos_z) - DW'(fz_reg);
                    pidx_reg  <= 3'd0;
                    bit_reg   <= '0;
                    acc_reg   <= '0;
                end
            end
            tffn_pkg::ST_MUL:
            begin
                // shift-add; top bit of the multiplier weighs negative
                logic signed [PW-1:0] acc_n;
                acc_n = acc_reg;
                if (mplr_reg[0])
                    acc_n = mul_last ? acc_reg - mcand_reg : acc_reg + mcand_reg;
                if (mul_last)
                begin
                    prod_reg[pidx_reg] <= acc_n;
                    pidx_reg <= pidx_reg + 3'd1;
                    bit_reg  <= '0;
                    acc_reg  <= '0;
                    case (pidx_reg)
                        3'd0: begin mcand_reg <= PW'(u_reg[2]); mplr_reg <= v_reg[1]; end
                        3'd1: begin mcand_reg <= PW'(u_reg[2]); mplr_reg <= v_reg[0]; end
                        3'd2: begin mcand_reg <= PW'(u_reg[0]); mplr_reg <= v_reg[2]; end
                        3'd3: begin mcand_reg <= PW'(u_reg[0]); mplr_reg <= v_reg[1]; end
                        3'd4: begin mcand_reg <= PW'(u_reg[1]); mplr_reg <= v_reg[0]; end
                        default: begin mcand_reg <= '0; mplr_reg <= '0; end
                    endcase
                end
                else
                begin
                    acc_reg   <= acc_n;
                    mcand_reg <= mcand_reg <<< 1;
                    mplr_reg  <= mplr_reg >> 1;
                    bit_reg   <= bit_reg + 1'b1;
                end
            end
            tffn_pkg::ST_CROSS:
            begin
                logic signed [CW-1:0] c0, c1, c2;
                c0 = CW'(prod_reg[0]) - CW'(prod_reg[1]);
                c1 = CW'(prod_reg[2]) - CW'(prod_reg[3]);
                c2 = CW'(prod_reg[4]) - CW'(prod_reg[5]);
                cr_reg[0] <= c0; cr_reg[1] <= c1; cr_reg[2] <= c2;
                mag_reg[0] <= MW'(c0 < 0 ? -c0 : c0);
                mag_reg[1] <= MW'(c1 < 0 ? -c1 : c1);
                mag_reg[2] <= MW'(c2 < 0 ? -c2 : c2);
            end
            tffn_pkg::ST_MAX:
            begin
                q_reg[0] <= tffn_pkg::SH_WIDTH'(mag_reg[0]);
                q_reg[1] <= tffn_pkg::SH_WIDTH'(mag_reg[1]);
                q_reg[2] <= tffn_pkg::SH_WIDTH'(mag_reg[2]);
                zero_reg <= mag_zero;
            end
            tffn_pkg::ST_NORM:
            begin
                // one shift step a cycle toward [2^30, 2^31)
                if (max_big)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                        q_reg[i]   <= tffn_pkg::SH_WIDTH'(mag_reg[i] >> 1);
                    end
                end
                else if (max_small)
                begin
                    for (int i = 0; i < 3; i++)
                        q_reg[i] <= q_reg[i] << 1;
                end
                else
                begin
                    ci_reg  <= 2'd0;
                    bit_reg <= '0;
                    s_reg   <= '0;
                    dvd_reg <= {16'd0, q_reg[0]};
                end
            end
            tffn_pkg::ST_SQ:
            begin
                // square each q by shift-add, bit selected from dvd_reg
                if (dvd_reg[0])
                    s_reg <= s_reg + (tffn_pkg::SUM_WIDTH'(q_reg[ci_reg]) << bit_reg);
                dvd_reg <= dvd_reg >> 1;
                if (sq_last)
                begin
                    bit_reg <= '0;
                    ci_reg  <= ci_reg + 2'd1;
                    dvd_reg <= (ci_reg == 2'd0) ? {16'd0, q_reg[1]} : {16'd0, q_reg[2]};
                    rem_reg  <= '0;
                    root_reg <= '0;
                end
                else
                begin
                    bit_reg <= bit_reg + 1'b1;
                end
            end
            tffn_pkg::ST_SQRT:
            begin
                // restoring root: two radicand bits in, one root bit out
                logic [tffn_pkg::SUM_WIDTH-1:0] r_n, t;
                r_n = (rem_reg << 2) | tffn_pkg::SUM_WIDTH'(s_reg[63:62]);
                t   = tffn_pkg::SUM_WIDTH'({root_reg, 2'b01});
                if (r_n >= t)
                begin
                    rem_reg  <= r_n - t;
                    root_reg <= {root_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= r_n;
                    root_reg <= {root_reg[30:0], 1'b0};
                end
                s_reg <= s_reg << 2;
                if (sqrt_last)
                    ci_reg <= 2'd0;
                else
                    bit_reg <= bit_reg + 1'b1;
            end
            tffn_pkg::ST_NEXT:
            begin
                dvd_reg  <= (tffn_pkg::DIV_WIDTH'(q_reg[ci_reg]) << tffn_pkg::NORM_ONE_SHIFT)
                          + tffn_pkg::DIV_WIDTH'(root_reg >> 1);
                drem_reg <= '0;
                quo_reg  <= '0;
                bit_reg  <= '0;
            end
            tffn_pkg::ST_DIV:
            begin
                // restoring division, one quotient bit a cycle
                logic [tffn_pkg::DIV_WIDTH-1:0] d_n, qv;
                logic [15:0] nm;
                d_n = {drem_reg[46:0], dvd_reg[47]};
                qv  = quo_reg << 1;
                if (d_n >= tffn_pkg::DIV_WIDTH'(root_reg))
                begin
                    d_n = d_n - tffn_pkg::DIV_WIDTH'(root_reg);
                    qv[0] = 1'b1;
                end
                drem_reg <= d_n;
                quo_reg  <= qv;
                dvd_reg  <= dvd_reg << 1;
                bit_reg  <= bit_reg + 1'b1;
                if (div_last)
                begin
                    nm = cr_reg[ci_reg] < 0 ? 16'(-qv) : 16'(qv);
                    n_reg[ci_reg] <= nm;
                    ci_reg <= ci_reg + 2'd1;
                end
            end
            tffn_pkg::ST_OUT:
            begin
                if (zero_reg)
                begin
                    n_reg[0] <= '0; n_reg[1] <= '0; n_reg[2] <= '0;
                end
            end
            default: ;
        endcase
    end

    // Largest magnitude: pick it in MAX, shift it along with the others in NORM
    always_ff @(posedge clk)
    begin
        if (state_reg == tffn_pkg::ST_MAX)
        begin
            m_reg <= MXW'((mag_reg[0] >= mag_reg[1] && mag_reg[0] >= mag_reg[2]) ? mag_reg[0]
                   : (mag_reg[1] >= mag_reg[2]) ? mag_reg[1] : mag_reg[2]);
        end
        else if (state_reg == tffn_pkg::ST_NORM)
        begin
            if (max_big)
                m_reg <= m_reg >> 1;
            else if (max_small)
                m_reg <= m_reg << 1;
        end
    end

    assign out_valid = out_valid_reg;
    assign a_x = fx_reg; assign a_y = fy_reg; assign a_z = fz_reg;
    assign b_x = px_reg; assign b_y = py_reg; assign b_z = pz_reg;
    assign c_x = cx_reg; assign c_y = cy_reg; assign c_z = cz_reg;
    assign norm_x = n_reg[0];
    assign norm_y = n_reg[1];
    assign norm_z = n_reg[2];

endmodule

[verif/triangle_fan_face_normals_tb.sv]
`timescale 1ns / 100ps

module triangle_fan_face_normals_tb;

    localparam int CW          = 16;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_WAIT  = 400;
    localparam logic [15:0] NORM_ONE = 16'd16384;

    typedef struct packed {
        logic        start;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
    } point_req_t;

    typedef struct packed {
        logic [15:0] ax, ay, az, bx, by, bz, cx, cy, cz, nx, ny, nz;
    } fan_tri_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic start_req = 1'b0;
    logic signed [CW-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic out_valid;
    logic out_stall = 1'b1;
    logic signed [CW-1:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
    logic signed [15:0] norm_x, norm_y, norm_z;

    triangle_fan_face_normals #(.COORD_WIDTH(CW)) DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .start_req(start_req), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .a_x(a_x), .a_y(a_y), .a_z(a_z), .b_x(b_x), .b_y(b_y), .b_z(b_z),
        .c_x(c_x), .c_y(c_y), .c_z(c_z),
        .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z)
    );

    always #2 clk = ~clk;

    point_req_t pending_points[$];
    fan_tri_t   expected_tris[$];
    int  mismatch_count = 0;
    int  tri_count = 0;
    int  req_count = 0;
    int  cycle_count = 0;
    bit  hold_off = 1'b0;

    // Fan state mirrored from the block
    logic signed [15:0] fan_first [3];
    logic signed [15:0] fan_prev [3];
    int fan_count = 0;

    function automatic logic [63:0] int_sqrt(logic [63:0] val);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > val)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (val >= res + bitv)
            begin
                val = val - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Unit normal of cross(b - a, c - a) in Q1.14
    function automatic void unit_normal(input logic signed [15:0] pa [3],
                                        input logic signed [15:0] pb [3],
                                        input logic signed [15:0] pc [3],
                                        output logic [15:0] nrm [3]);
        longint u [3];
        longint v [3];
        longint cr [3];
        logic [63:0] q [3];
        logic [63:0] m, s, r, n;
        for (int i = 0; i < 3; i++)
        begin
            u[i] = longint'(pb[i]) - longint'(pa[i]);
            v[i] = longint'(pc[i]) - longint'(pa[i]);
        end
        cr[0] = u[1] * v[2] - u[2] * v[1];
        cr[1] = u[2] * v[0] - u[0] * v[2];
        cr[2] = u[0] * v[1] - u[1] * v[0];
        m = 0;
        for (int i = 0; i < 3; i++)
        begin
            q[i] = (cr[i] < 0) ? -cr[i] : cr[i];
            if (q[i] > m)
                m = q[i];
        end
        if (m == 0)
        begin
            for (int i = 0; i < 3; i++)
                nrm[i] = '0;
            return;
        end
        while (m >= (64'd1 << 31))
        begin
            m = m >> 1;
            for (int i = 0; i < 3; i++)
                q[i] = q[i] >> 1;
        end
        while (m < (64'd1 << 30))
        begin
            m = m << 1;
            for (int i = 0; i < 3; i++)
                q[i] = q[i] << 1;
        end
        s = q[0] * q[0] + q[1] * q[1] + q[2] * q[2];
        r = int_sqrt(s);
        for (int i = 0; i < 3; i++)
        begin
            n = (q[i] * NORM_ONE + (r >> 1)) / r;
            if (cr[i] < 0)
                n = -n;
            nrm[i] = n[15:0];
        end
    endfunction

    // Advance the fan state for one accepted request
    task automatic fan_advance(input point_req_t req);
        logic signed [15:0] pt [3];
        logic [15:0] nrm [3];
        fan_tri_t tri_exp;
        pt[0] = req.x;
        pt[1] = req.y;
        pt[2] = req.z;
        if (req.start || fan_count == 0)
        begin
            fan_first = pt;
            fan_prev = pt;
            fan_count = 1;
        end
        else if (fan_count == 1)
        begin
            fan_prev = pt;
            fan_count = 2;
        end
        else
        begin
            unit_normal(fan_first, fan_prev, pt, nrm);
            tri_exp = '{fan_first[0], fan_first[1], fan_first[2],
                        fan_prev[0], fan_prev[1], fan_prev[2],
                        pt[0], pt[1], pt[2], nrm[0], nrm[1], nrm[2]};
            expected_tris.insert(expected_tris.size(), tri_exp);
            fan_prev = pt;
        end
    endtask

    task automatic report(input string what, input logic [15:0] got,
                          input logic [15:0] want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what,
                 $signed(got), $signed(want), cycle_count);
        mismatch_count++;
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'($signed($urandom_range(0, 40)) - 20);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic point_req_t mk_point(logic st, logic [15:0] x, logic [15:0] y,
                                            logic [15:0] z);
        point_req_t p;
        p.start = st;
        p.x = x;
        p.y = y;
        p.z = z;
        return p;
    endfunction

    // Queue one request at the back of the pending list
    task automatic add_point(input logic st, input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z);
        pending_points.insert(pending_points.size(), mk_point(st, x, y, z));
    endtask

    // Driver: offer the queued requests with random gaps
    int send_gap = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                fan_advance(mk_point(start_req, pos_x, pos_y, pos_z));
                req_count++;
            end
            if (in_valid && in_stall)
                ;
            else if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_points.size() > 0)
            begin
                point_req_t p;
                p = pending_points.pop_front();
                in_valid <= 1'b1;
                start_req <= p.start;
                pos_x <= p.x;
                pos_y <= p.y;
                pos_z <= p.z;
                send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: check each accepted triangle and draw the next stall
    int recv_gap = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                fan_tri_t got;
                fan_tri_t want;
                got = '{a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                        norm_x, norm_y, norm_z};
                tri_count++;
                if (expected_tris.size() == 0)
                begin
                    $display("MISMATCH unexpected triangle at cycle %0d", cycle_count);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_tris.pop_front();
                    if (got.ax != want.ax) report("a_x", got.ax, want.ax);
                    if (got.ay != want.ay) report("a_y", got.ay, want.ay);
                    if (got.az != want.az) report("a_z", got.az, want.az);
                    if (got.bx != want.bx) report("b_x", got.bx, want.bx);
                    if (got.by != want.by) report("b_y", got.by, want.by);
                    if (got.bz != want.bz) report("b_z", got.bz, want.bz);
                    if (got.cx != want.cx) report("c_x", got.cx, want.cx);
                    if (got.cy != want.cy) report("c_y", got.cy, want.cy);
                    if (got.cz != want.cz) report("c_z", got.cz, want.cz);
                    if (got.nx != want.nx) report("norm_x", got.nx, want.nx);
                    if (got.ny != want.ny) report("norm_y", got.ny, want.ny);
                    if (got.nz != want.nz) report("norm_z", got.nz, want.nz);
                end
                recv_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            end
            if (recv_gap > 0)
                recv_gap = recv_gap - 1;
            out_stall <= hold_off || (recv_gap > 0);
        end
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // Long receiver hold-off while the sender keeps offering
    initial
    begin
        wait (req_count >= 150);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (3000) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        logic [15:0] ext [4];
        ext = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
        // Point without a started polygon, then a plain fan
        add_point(1'b0, 16'd10, 16'd0, 16'd0);
        add_point(1'b0, 16'd0, 16'd10, 16'd0);
        add_point(1'b0, 16'd0, 16'd0, 16'd10);
        add_point(1'b0, 16'd5, 16'd5, 16'd5);
        // Degenerate: collinear and repeated points
        add_point(1'b1, 16'd1, 16'd1, 16'd1);
        add_point(1'b0, 16'd2, 16'd2, 16'd2);
        add_point(1'b0, 16'd3, 16'd3, 16'd3);
        add_point(1'b0, 16'd3, 16'd3, 16'd3);
        // Start inside a polygon, and polygons of one and two points
        add_point(1'b1, 16'd7, 16'd8, 16'd9);
        add_point(1'b1, 16'd4, 16'd4, 16'd4);
        add_point(1'b0, 16'd9, 16'd4, 16'd4);
        // Extreme coordinates
        add_point(1'b1, ext[0], ext[0], ext[0]);
        add_point(1'b0, ext[1], ext[0], ext[1]);
        add_point(1'b0, ext[0], ext[1], ext[1]);
        add_point(1'b0, ext[1], ext[1], ext[0]);
        add_point(1'b0, ext[3], ext[2], ext[1]);
        add_point(1'b1, ext[1], ext[1], ext[1]);
        add_point(1'b0, ext[0], ext[1], ext[1]);
        add_point(1'b0, ext[1], ext[0], ext[1]);
        add_point(1'b0, ext[1], ext[1], ext[0]);
        // Random polygons, mostly three or more points
        while (pending_points.size() < 1250)
        begin
            int npts;
            npts = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
            for (int k = 0; k < npts; k++)
                add_point(k == 0 ? 1'b1 : ($urandom_range(0, 40) == 0),
                          rand_coord(), rand_coord(), rand_coord());
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_points.size() == 0 && !in_valid);
        wait (expected_tris.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("Sent %0d points as fan polygons, checked %0d triangles with normals",
                 req_count, tri_count);
        $display("Covered extremes, degenerate faces, restarts and a long output hold-off");
        if (mismatch_count == 0 && expected_tris.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[sim.f]
design/tffn_pkg.sv
design/triangle_fan_face_normals.sv
verif/triangle_fan_face_normals_tb.sv
